FILE: hdl/mcv_pkg.sv
// Package for the MIDI to CV message handler: payload structs, message
// codes, register indexes and fixed constants. No dependencies.
package mcv_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] midi_byte;
  } mcv_in_t;

  typedef struct packed {
    logic [11:0] pitch_level;
    logic        pitch_write;
    logic [11:0] bend_level;
    logic        bend_write;
    logic [6:0]  mod_level;
    logic        mod_write;
    logic [6:0]  velocity_level;
    logic        velocity_write;
    logic        gate;
    logic        trigger;
  } mcv_out_t;

  typedef struct packed {
    logic [3:0] midi_channel;
    logic [6:0] lowest_note;
    logic [6:0] highest_note;
    logic [7:0] trigger_time;
    logic       retrigger_enable;
  } mcv_cfg_t;

  // One parsed event handed from the parser to the voice logic.
  typedef struct packed {
    logic       tick;
    logic       valid;
    logic [3:0] kind;
    logic [3:0] chan;
    logic [6:0] a;
    logic [6:0] b;
  } mcv_msg_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_NOTE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_NOTE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TIME     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRIGGER_ENABLE = 3'd4;

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CC       = 4'hB;
  localparam logic [3:0] KIND_BEND     = 4'hE;

  localparam logic [7:0]  SYSTEM_FIRST  = 8'hF0;
  localparam logic [6:0]  CC_MOD_WHEEL  = 7'd1;
  localparam logic [6:0]  BEND_CENTER   = 7'h40;
  localparam logic [11:0] ONE_VOLT_CODE = 12'd819;
  localparam int          CODE_MAX      = 4095;

  localparam mcv_cfg_t CFG_RESET = '{
    midi_channel:     4'd15,
    lowest_note:      7'd24,
    highest_note:     7'd84,
    trigger_time:     8'd254,
    retrigger_enable: 1'b1
  };

endpackage

FILE: hdl/mcv_parser.sv
// Running-status MIDI byte parser: turns bytes into three-byte channel
// messages and passes timer ticks through. Depends on mcv_pkg.
module mcv_parser
  import mcv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  mcv_in_t  item,
  output mcv_msg_t msg
);

  logic [7:0] running_status, running_status_next;
  logic       expect_second, expect_second_next;
  logic [6:0] first_data, first_data_next;

  always_comb begin
    running_status_next = running_status;
    expect_second_next  = expect_second;
    first_data_next     = first_data;
    msg.tick  = item.cmd;
    msg.valid = 1'b0;
    msg.kind  = running_status[7:4];
    msg.chan  = running_status[3:0];
    msg.a     = first_data;
    msg.b     = item.midi_byte[6:0];
    // System bytes are dropped without touching the running status.
    if (!item.cmd && item.midi_byte < SYSTEM_FIRST) begin
      if (item.midi_byte[7]) begin
        running_status_next = item.midi_byte;
        expect_second_next  = 1'b0;
      end else if (expect_second) begin
        expect_second_next = 1'b0;
        msg.valid          = 1'b1;
      end else if (running_status != 8'd0) begin
        first_data_next    = item.midi_byte[6:0];
        expect_second_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= 8'd0;
      expect_second  <= 1'b0;
      first_data     <= 7'd0;
    end else if (fire) begin
      running_status <= running_status_next;
      expect_second  <= expect_second_next;
      first_data     <= first_data_next;
    end
  end

endmodule

FILE: hdl/mcv_voice.sv
// Voice state of the converter: pitch table, note, bend, mod and trigger
// pulse handling. Builds the result item. Depends on mcv_pkg.
module mcv_voice
  import mcv_pkg::*;
#(
  parameter int TABLE_ENTRIES = 61
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  mcv_cfg_t  cfg,
  input  mcv_msg_t  msg,
  output mcv_out_t  result
);

  localparam int SPAN  = TABLE_ENTRIES - 1;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic [11:0] pitch_rom [TABLE_ENTRIES];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_rom
    localparam int RAW = (i * 8192 + SPAN) / (2 * SPAN);
    localparam int VAL = (RAW > CODE_MAX) ? CODE_MAX : RAW;
    assign pitch_rom[i] = 12'(VAL);
  end

  logic [6:0]  previous_bend, previous_bend_next;
  logic [11:0] bend_value, bend_value_next;
  logic [6:0]  held_note, held_note_next;
  logic        gate_on, gate_on_next;
  logic        trigger_on, trigger_on_next;
  logic        pulse_active, pulse_active_next;
  logic [7:0]  pulse_ticks, pulse_ticks_next;
  logic [11:0] pitch_value, pitch_value_next;
  logic [6:0]  mod_value, mod_value_next;
  logic [6:0]  velocity_value, velocity_value_next;
  logic        wr_pitch, wr_bend, wr_mod, wr_vel;

  logic [6:0]       note_offset;
  logic [IDX_W-1:0] rom_idx;
  logic [7:0]       tick_count;
  logic             release_hit;

  assign note_offset = msg.a - cfg.lowest_note;
  assign rom_idx     = ({1'b0, note_offset} > 8'(SPAN)) ? IDX_W'(SPAN)
                                                        : note_offset[IDX_W-1:0];
  assign tick_count  = pulse_ticks + 8'd1;
  assign release_hit = (held_note == msg.a);

  always_comb begin
    previous_bend_next  = previous_bend;
    bend_value_next     = bend_value;
    held_note_next      = held_note;
    gate_on_next        = gate_on;
    trigger_on_next     = trigger_on;
    pulse_active_next   = pulse_active;
    pulse_ticks_next    = pulse_ticks;
    pitch_value_next    = pitch_value;
    mod_value_next      = mod_value;
    velocity_value_next = velocity_value;
    wr_pitch = 1'b0;
    wr_bend  = 1'b0;
    wr_mod   = 1'b0;
    wr_vel   = 1'b0;

    if (msg.tick) begin
      if (pulse_active) begin
        if (tick_count >= cfg.trigger_time) begin
          pulse_ticks_next  = 8'd0;
          pulse_active_next = 1'b0;
          trigger_on_next   = 1'b0;
        end else begin
          pulse_ticks_next = tick_count;
        end
      end
    end else if (msg.valid && msg.chan == cfg.midi_channel) begin
      unique case (msg.kind)
        KIND_CC: begin
          if (msg.a == CC_MOD_WHEEL) begin
            mod_value_next = msg.b;
            wr_mod         = 1'b1;
          end
        end
        KIND_BEND: begin
          if (msg.b != previous_bend) begin
            bend_value_next = ONE_VOLT_CODE + 12'(msg.b);
          end else if (msg.b == BEND_CENTER) begin
            bend_value_next = ONE_VOLT_CODE;
          end
          wr_bend            = 1'b1;
          previous_bend_next = msg.b;
        end
        KIND_NOTE_ON: begin
          if (msg.a != 7'd0 && msg.a >= cfg.lowest_note && msg.a <= cfg.highest_note) begin
            if (msg.b == 7'd0) begin
              // Zero velocity is a note off for this note.
              if (release_hit) begin
                gate_on_next        = 1'b0;
                trigger_on_next     = 1'b0;
                pulse_active_next   = 1'b0;
                velocity_value_next = 7'd0;
                wr_vel              = 1'b1;
              end
            end else begin
              pitch_value_next    = pitch_rom[rom_idx];
              wr_pitch            = 1'b1;
              velocity_value_next = msg.b;
              wr_vel              = 1'b1;
              if (!gate_on) begin
                gate_on_next      = 1'b1;
                trigger_on_next   = 1'b1;
                pulse_active_next = 1'b1;
              end else if (cfg.retrigger_enable) begin
                trigger_on_next   = 1'b1;
                pulse_active_next = 1'b1;
              end
              pulse_ticks_next = 8'd0;
              held_note_next   = msg.a;
            end
          end
        end
        KIND_NOTE_OFF: begin
          if (msg.a >= cfg.lowest_note && release_hit) begin
            gate_on_next        = 1'b0;
            trigger_on_next     = 1'b0;
            pulse_active_next   = 1'b0;
            velocity_value_next = 7'd0;
            wr_vel              = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.pitch_level    = pitch_value_next;
    result.pitch_write    = wr_pitch;
    result.bend_level     = bend_value_next;
    result.bend_write     = wr_bend;
    result.mod_level      = mod_value_next;
    result.mod_write      = wr_mod;
    result.velocity_level = velocity_value_next;
    result.velocity_write = wr_vel;
    result.gate           = gate_on_next;
    result.trigger        = trigger_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_bend  <= BEND_CENTER;
      bend_value     <= ONE_VOLT_CODE;
      held_note      <= 7'd0;
      gate_on        <= 1'b0;
      trigger_on     <= 1'b0;
      pulse_active   <= 1'b0;
      pulse_ticks    <= 8'd0;
      pitch_value    <= 12'd0;
      mod_value      <= 7'd0;
      velocity_value <= 7'd0;
    end else if (fire) begin
      previous_bend  <= previous_bend_next;
      bend_value     <= bend_value_next;
      held_note      <= held_note_next;
      gate_on        <= gate_on_next;
      trigger_on     <= trigger_on_next;
      pulse_active   <= pulse_active_next;
      pulse_ticks    <= pulse_ticks_next;
      pitch_value    <= pitch_value_next;
      mod_value      <= mod_value_next;
      velocity_value <= velocity_value_next;
    end
  end

endmodule

FILE: hdl/midi_to_cv_message_handler.sv
// Monophonic MIDI to CV message handler, top level.
// An accepted item passes through the input register, then the result register;
// one item per cycle sustained while out_stall stays low.
// The rate is set by the single pass from input register to result register.
// Reset (synchronous, rst high) empties both registers and loads register
// and voice reset values; there is no clearing pass. Depends on mcv_pkg.
module midi_to_cv_message_handler
  import mcv_pkg::*;
#(
  parameter int TABLE_ENTRIES = 61
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mcv_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mcv_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  mcv_cfg_t cfg;
  logic     s1_valid;
  mcv_in_t  s1_data;
  logic     advance;
  mcv_msg_t msg;
  mcv_out_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIDI_CHANNEL:     cfg.midi_channel     <= cfg_data[3:0];
        CFG_LOWEST_NOTE:      cfg.lowest_note      <= cfg_data[6:0];
        CFG_HIGHEST_NOTE:     cfg.highest_note     <= cfg_data[6:0];
        CFG_TRIGGER_TIME:     cfg.trigger_time     <= cfg_data;
        CFG_RETRIGGER_ENABLE: cfg.retrigger_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The input register moves on whenever the result register has room.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  mcv_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (s1_data),
    .msg  (msg)
  );

  mcv_voice #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_voice (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .cfg    (cfg),
    .msg    (msg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  a_trigger_needs_gate: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.trigger || out_data.gate))
    else $error("trigger high while gate is low");

  a_velocity_follows_gate: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.gate == (out_data.velocity_level != 7'd0)))
    else $error("velocity level does not match gate");

  a_pitch_with_velocity: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.pitch_write) |-> out_data.velocity_write)
    else $error("pitch written without velocity");

  a_bend_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.bend_level >= ONE_VOLT_CODE &&
                   out_data.bend_level <= ONE_VOLT_CODE + 12'd127))
    else $error("bend level out of range");

endmodule

FILE: tb/midi_to_cv_message_handler_monitor.sv
`timescale 1ns / 100ps
// Monitor for the MIDI to CV message handler: models the parser and voice,
// queues one expected result per accepted item and compares the results.
// Depends on mcv_pkg.
module midi_to_cv_message_handler_monitor
  import mcv_pkg::*;
#(
  parameter int TABLE_ENTRIES = 61
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  mcv_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  mcv_out_t             out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   mismatch_count,
  output int                   results_pending
);

  mcv_cfg_t    voice_cfg;
  logic [7:0]  running_status;
  logic        second_data_due;
  logic [6:0]  first_data;
  logic [6:0]  previous_bend;
  logic [11:0] bend_value;
  logic [6:0]  held_note;
  logic        gate_on;
  logic        trigger_on;
  logic        pulse_active;
  logic [7:0]  pulse_ticks;
  logic [11:0] pitch_value;
  logic [6:0]  mod_value;
  logic [6:0]  velocity_value;

  mcv_out_t expected_voice_q[$];
  mcv_out_t predicted;
  mcv_out_t oldest;
  int       fault_count = 0;

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fault_count++;
    end
  endfunction

  // Only the note played last can be released.
  task automatic release_held(input logic [6:0] note, inout mcv_out_t res);
    if (held_note == note) begin
      gate_on        = 1'b0;
      trigger_on     = 1'b0;
      pulse_active   = 1'b0;
      velocity_value = '0;
      res.velocity_write = 1'b1;
    end
  endtask

  task automatic predict_voice_item(input mcv_in_t item, output mcv_out_t res);
    logic [6:0] a;
    logic [6:0] b;
    int         idx;
    int         span;
    int         code;
    res  = '0;
    a    = first_data;
    b    = item.midi_byte[6:0];
    span = TABLE_ENTRIES - 1;
    if (item.cmd) begin
      if (pulse_active) begin
        pulse_ticks = pulse_ticks + 8'd1;
        if (pulse_ticks >= voice_cfg.trigger_time) begin
          pulse_ticks  = '0;
          pulse_active = 1'b0;
          trigger_on   = 1'b0;
        end
      end
    end else if (item.midi_byte < SYSTEM_FIRST) begin
      if (item.midi_byte[7]) begin
        running_status  = item.midi_byte;
        second_data_due = 1'b0;
      end else if (second_data_due) begin
        second_data_due = 1'b0;
        if (running_status[3:0] == voice_cfg.midi_channel) begin
          case (running_status[7:4])
            KIND_CC: begin
              if (a == CC_MOD_WHEEL) begin
                mod_value     = b;
                res.mod_write = 1'b1;
              end
            end
            KIND_BEND: begin
              // A repeat at center recenters; other repeats keep the code.
              if (b != previous_bend) bend_value = ONE_VOLT_CODE + b;
              else if (b == BEND_CENTER) bend_value = ONE_VOLT_CODE;
              res.bend_write = 1'b1;
              previous_bend  = b;
            end
            KIND_NOTE_ON: begin
              if (a != 0 && a >= voice_cfg.lowest_note && a <= voice_cfg.highest_note) begin
                if (b == 0) begin
                  release_held(a, res);
                end else begin
                  idx = int'(a) - int'(voice_cfg.lowest_note);
                  if (idx > span) idx = span;
                  code = (idx * 8192 + span) / (2 * span);
                  if (code > CODE_MAX) code = CODE_MAX;
                  pitch_value        = 12'(code);
                  res.pitch_write    = 1'b1;
                  velocity_value     = b;
                  res.velocity_write = 1'b1;
                  if (!gate_on) begin
                    gate_on      = 1'b1;
                    trigger_on   = 1'b1;
                    pulse_active = 1'b1;
                  end else if (voice_cfg.retrigger_enable) begin
                    trigger_on   = 1'b1;
                    pulse_active = 1'b1;
                  end
                  pulse_ticks = '0;
                  held_note   = a;
                end
              end
            end
            KIND_NOTE_OFF: begin
              if (a >= voice_cfg.lowest_note) release_held(a, res);
            end
            default: ;
          endcase
        end
      end else if (running_status != 0) begin
        first_data      = b;
        second_data_due = 1'b1;
      end
    end
    res.pitch_level    = pitch_value;
    res.bend_level     = bend_value;
    res.mod_level      = mod_value;
    res.velocity_level = velocity_value;
    res.gate           = gate_on;
    res.trigger        = trigger_on;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      voice_cfg       = CFG_RESET;
      running_status  = '0;
      second_data_due = 1'b0;
      first_data      = '0;
      previous_bend   = BEND_CENTER;
      bend_value      = ONE_VOLT_CODE;
      held_note       = '0;
      gate_on         = 1'b0;
      trigger_on      = 1'b0;
      pulse_active    = 1'b0;
      pulse_ticks     = '0;
      pitch_value     = '0;
      mod_value       = '0;
      velocity_value  = '0;
      expected_voice_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIDI_CHANNEL:     voice_cfg.midi_channel     = cfg_data[3:0];
          CFG_LOWEST_NOTE:      voice_cfg.lowest_note      = cfg_data[6:0];
          CFG_HIGHEST_NOTE:     voice_cfg.highest_note     = cfg_data[6:0];
          CFG_TRIGGER_TIME:     voice_cfg.trigger_time     = cfg_data;
          CFG_RETRIGGER_ENABLE: voice_cfg.retrigger_enable = cfg_data[0];
          default: ;
        endcase
      end
      // Results leave before this edge's item is queued; the block cannot
      // return an item's result at the edge that accepts it.
      if (out_valid && !out_stall) begin
        if (expected_voice_q.size() == 0) begin
          $display("%0t: result with none expected, got %p", $time, out_data);
          fault_count++;
        end else begin
          oldest = expected_voice_q.pop_front();
          check_field("pitch_level", oldest.pitch_level, out_data.pitch_level);
          check_field("pitch_write", oldest.pitch_write, out_data.pitch_write);
          check_field("bend_level", oldest.bend_level, out_data.bend_level);
          check_field("bend_write", oldest.bend_write, out_data.bend_write);
          check_field("mod_level", oldest.mod_level, out_data.mod_level);
          check_field("mod_write", oldest.mod_write, out_data.mod_write);
          check_field("velocity_level", oldest.velocity_level, out_data.velocity_level);
          check_field("velocity_write", oldest.velocity_write, out_data.velocity_write);
          check_field("gate", oldest.gate, out_data.gate);
          check_field("trigger", oldest.trigger, out_data.trigger);
        end
      end
      if (in_valid && !in_stall) begin
        predict_voice_item(in_data, predicted);
        expected_voice_q.push_back(predicted);
      end
    end
    results_pending <= expected_voice_q.size();
    mismatch_count  <= fault_count;
  end

endmodule

FILE: tb/midi_to_cv_message_handler_test.sv
`timescale 1ns / 100ps
// Top of the MIDI to CV message handler testbench: clock, reset, MIDI byte
// and tick stimulus, register phases and verdict. Depends on mcv_pkg, the
// block and midi_to_cv_message_handler_monitor.
module midi_to_cv_message_handler_test
  import mcv_pkg::*;
();

  localparam int TABLE_ENTRIES = 61;
  localparam int QUIET_LIMIT   = 5000;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  mcv_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  mcv_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  int mismatch_count;
  int results_pending;
  int quiet_cycles  = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 84;
  int voice_items   = 0;

  logic [7:0] last_status = '0;
  logic [6:0] last_note   = 7'd60;
  logic [6:0] last_bend   = BEND_CENTER;
  mcv_cfg_t   cur_cfg     = CFG_RESET;

  midi_to_cv_message_handler #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  midi_to_cv_message_handler_monitor #(.TABLE_ENTRIES(TABLE_ENTRIES)) voice_monitor (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("midi_to_cv_message_handler_test failed");
      $finish;
    end
  end

  // Valid stays high between back-to-back items; it only drops in a gap.
  task automatic send_item(input logic is_tick, input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {is_tick, value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (is_tick || value < SYSTEM_FIRST) voice_items++;
    if (!is_tick && value[7] && value < SYSTEM_FIRST) last_status = value;
  endtask

  task automatic send_msg(input logic [7:0] status, input logic [6:0] first,
                          input logic [6:0] second);
    if (status != last_status || $urandom_range(1) == 0) send_item(1'b0, status);
    send_item(1'b0, {1'b0, first});
    send_item(1'b0, {1'b0, second});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits beyond each register's width are randomized.
  task automatic configure(input mcv_cfg_t setting);
    drain();
    write_reg(CFG_MIDI_CHANNEL, {4'($urandom), setting.midi_channel});
    write_reg(CFG_LOWEST_NOTE, {1'($urandom), setting.lowest_note});
    write_reg(CFG_HIGHEST_NOTE, {1'($urandom), setting.highest_note});
    write_reg(CFG_TRIGGER_TIME, setting.trigger_time);
    write_reg(CFG_RETRIGGER_ENABLE, {7'($urandom), setting.retrigger_enable});
    cur_cfg = setting;
  endtask

  task automatic random_event();
    int         pick;
    logic [3:0] other_chan;
    logic [6:0] note;
    logic [6:0] velocity;
    pick = $urandom_range(99);
    if (pick < 35) begin
      if ($urandom_range(9) < 7 && cur_cfg.lowest_note <= cur_cfg.highest_note)
        note = 7'($urandom_range(cur_cfg.highest_note, cur_cfg.lowest_note));
      else
        note = 7'($urandom_range(127));
      velocity  = ($urandom_range(99) < 15) ? 7'd0 : 7'($urandom_range(127, 1));
      last_note = note;
      send_msg({KIND_NOTE_ON, cur_cfg.midi_channel}, note, velocity);
    end else if (pick < 50) begin
      note = ($urandom_range(9) < 6) ? last_note : 7'($urandom_range(127));
      send_msg({KIND_NOTE_OFF, cur_cfg.midi_channel}, note, 7'($urandom_range(127)));
    end else if (pick < 60) begin
      note = ($urandom_range(9) < 7) ? CC_MOD_WHEEL : 7'($urandom_range(127));
      send_msg({KIND_CC, cur_cfg.midi_channel}, note, 7'($urandom_range(127)));
    end else if (pick < 70) begin
      case ($urandom_range(4))
        0, 1:    note = last_bend;
        2:       note = BEND_CENTER;
        default: note = 7'($urandom_range(127));
      endcase
      last_bend = note;
      send_msg({KIND_BEND, cur_cfg.midi_channel}, 7'($urandom_range(127)), note);
    end else if (pick < 80) begin
      repeat ($urandom_range(12, 1)) send_item(1'b1, 8'($urandom_range(255)));
    end else if (pick < 85) begin
      other_chan = cur_cfg.midi_channel + 4'($urandom_range(15, 1));
      send_msg({4'($urandom_range(14, 8)), other_chan}, 7'($urandom_range(127)),
               7'($urandom_range(127)));
    end else if (pick < 90) begin
      send_item(1'b0, 8'($urandom_range(255, 240)));
    end else if (pick < 95) begin
      // A message cut short by a new status.
      send_item(1'b0, {1'b1, 7'($urandom_range(111))});
      send_item(1'b0, {1'b0, 7'($urandom_range(127))});
    end else begin
      send_item(1'b0, 8'($urandom_range(255)));
    end
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    stop_at = voice_items + count;
    while (voice_items < stop_at) begin
      random_event();
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  initial begin
    logic [7:0] opening_bytes[$];
    mcv_cfg_t   setting;
    // Stray data, system byte, note on, legato note, note zero, zero
    // velocity release, note off for another note, mod wheel, other CC,
    // other channel, bend and a repeated bend.
    opening_bytes = '{8'h3C, 8'hFF, 8'h9F, 8'h3C, 8'h64, 8'h48, 8'h7F, 8'h00, 8'h32,
                      8'h48, 8'h00, 8'h8F, 8'h3C, 8'h00, 8'hBF, 8'h01, 8'h7F,
                      8'h07, 8'h09, 8'h80, 8'h00, 8'h7F, 8'hEF, 8'h00, 8'h7F,
                      8'h00, 8'h7F};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_bytes[i]) send_item(1'b0, opening_bytes[i]);
    drain();
    random_traffic(110);

    configure('{midi_channel: 4'd0, lowest_note: 7'd0, highest_note: 7'd127,
                trigger_time: 8'd0, retrigger_enable: 1'b0});
    random_traffic(120);

    send_idle_pct = 84;
    recv_idle_pct <= 22;
    configure('{midi_channel: 4'd5, lowest_note: 7'd10, highest_note: 7'd127,
                trigger_time: 8'd255, retrigger_enable: 1'b1});
    random_traffic(120);

    configure('{midi_channel: 4'd15, lowest_note: 7'd100, highest_note: 7'd127,
                trigger_time: 8'd1, retrigger_enable: 1'b0});
    random_traffic(120);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    setting.midi_channel     = 4'($urandom);
    setting.lowest_note      = 7'($urandom_range(60));
    setting.highest_note     = 7'($urandom_range(127, setting.lowest_note));
    setting.trigger_time     = 8'($urandom_range(10, 1));
    setting.retrigger_enable = 1'($urandom);
    configure(setting);
    random_traffic(180);

    configure('{midi_channel: 4'd3, lowest_note: 7'd127, highest_note: 7'd0,
                trigger_time: 8'd2, retrigger_enable: 1'b1});
    random_traffic(40);

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("midi_to_cv_message_handler_test passed");
    end else begin
      $display("midi_to_cv_message_handler_test failed");
    end
    $finish;
  end

endmodule
